// ----- design/rpt_pkg.sv -----
// Package for the radio preset table: transaction structs, opcodes,
// sequencer states and band constants. No dependencies.
`timescale 1ns / 1ps

package rpt_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // Band limits and rounding, in 10 kHz units
  localparam logic [13:0] BAND_LOW   = 14'd7600;
  localparam logic [13:0] BAND_HIGH  = 14'd10800;
  localparam logic [13:0] ROUND_HALF = 14'd5;
  // floor(x * RECIP_10 / 2**16) == floor(x / 10) for x below about 16000
  localparam logic [12:0] RECIP_10   = 13'd6554;

  // Configuration register indexes
  localparam logic [1:0] CFG_OFFSET_MIN = 2'd0;
  localparam logic [1:0] CFG_OFFSET_MAX = 2'd1;

  localparam logic signed [15:0] OFFSET_MIN_RST = -16'sd600;
  localparam logic signed [15:0] OFFSET_MAX_RST = 16'sd600;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_CALC,
    S_SEARCH,
    S_APPLY,
    S_STEP,
    S_RDSEL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        freq_in;
    logic signed [15:0] offset_in;
  } rpt_in_t;

  typedef struct packed {
    logic               ok;
    logic               hit;
    logic [3:0]         sel_index;
    logic [13:0]        sel_freq;
    logic signed [15:0] sel_offset;
    logic [4:0]         entry_count;
    logic               changed;
  } rpt_out_t;

  // One table entry
  typedef struct packed {
    logic [13:0]        freq;
    logic signed [15:0] offset;
  } entry_t;

endpackage

// ----- design/radio_preset_table.sv -----
// Top level of the radio preset table: sequencer, search compare unit,
// config registers and result register. Depends on rpt_pkg and rpt_store.
`timescale 1ns / 1ps
//
// Usage
//   in channel  : in_valid_i/in_ready_o carry one rpt_in_t transaction
//                 (add-or-select, step forward, step backward).
//   out channel : out_valid_o/out_ready_i carry one rpt_out_t per input.
//   cfg channel : cfg_valid_i/cfg_ready_o write offset_min (index 0) or
//                 offset_max (index 1); always ready, other indexes ignored.
// Sequence (accept to result valid)
//   add    : normalise, calculate, search, apply, read select, respond.
//            The table is scanned one entry per cycle through a single
//            comparator on the read port of the store; a hit ends the
//            scan early.
//   step   : step, read select, respond. Unused opcode: read select, respond.
//   The input is accepted again in the cycle after the result is registered;
//   one item is in work at a time.
// Reset: the table is empty, current index 0, offset limits -600/600.
// Stall: the result sits in the output register; the next item is taken
//   and worked on, and its result waits until the register is free.

module radio_preset_table
  import rpt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rpt_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rpt_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  // Control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic signed [15:0] off_min_q, off_max_q;

  // Working registers of one transaction
  logic [1:0]         op_q, op_d;
  logic [15:0]        freq_raw_q, freq_raw_d;
  logic signed [15:0] off_raw_q, off_raw_d;
  logic [10:0]        quot_q, quot_d;
  logic [13:0]        freq_q, freq_d;
  logic signed [15:0] off_q, off_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic               hit_q, hit_d;
  logic               ok_q, ok_d;
  logic               changed_q, changed_d;
  rpt_out_t           res_q, res_d;

  // Store ports
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_rdata;

  // Arithmetic helpers
  logic [13:0]        freq_clamp;
  logic [13:0]        freq_round;
  logic [26:0]        prod;
  logic signed [15:0] off_clamp;

  rpt_store #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Band clamp of the raw frequency, add half a step, then divide by ten via reciprocal
  always_comb begin
    if (freq_raw_q < 16'(BAND_LOW)) begin
      freq_clamp = BAND_LOW;
    end else if (freq_raw_q > 16'(BAND_HIGH)) begin
      freq_clamp = BAND_HIGH;
    end else begin
      freq_clamp = freq_raw_q[13:0];
    end
    prod = 27'(freq_clamp + ROUND_HALF) * 27'(RECIP_10);
  end

  // Times ten by shift-add; the result stays inside the band
  assign freq_round = 14'({quot_q, 3'b000}) + 14'({quot_q, 1'b0});

  // Offset clamp, lower limit checked first
  always_comb begin
    if (off_raw_q < off_min_q) begin
      off_clamp = off_min_q;
    end else if (off_raw_q > off_max_q) begin
      off_clamp = off_max_q;
    end else begin
      off_clamp = off_raw_q;
    end
  end

  // Config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_min_q <= OFFSET_MIN_RST;
      off_max_q <= OFFSET_MAX_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_OFFSET_MIN) begin
        off_min_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_OFFSET_MAX) begin
        off_max_q <= cfg_data_i;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    cmp_vld_d   = cmp_vld_q;
    op_d        = op_q;
    freq_raw_d  = freq_raw_q;
    off_raw_d   = off_raw_q;
    quot_d      = quot_q;
    freq_d      = freq_q;
    off_d       = off_q;
    ptr_d       = ptr_q;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    hit_d       = hit_q;
    ok_d        = ok_q;
    changed_d   = changed_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = '{freq: freq_q, offset: off_q};
    mem_raddr   = cur_q;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_data_i.opcode;
          freq_raw_d = in_data_i.freq_in;
          off_raw_d  = in_data_i.offset_in;
          ok_d       = 1'b0;
          hit_d      = 1'b0;
          changed_d  = 1'b0;
          case (in_data_i.opcode)
            OP_ADD:  state_d = S_NORM;
            OP_NEXT: state_d = S_STEP;
            OP_PREV: state_d = S_STEP;
            default: state_d = S_RDSEL;
          endcase
        end
      end

      S_NORM: begin
        quot_d  = prod[26:16];
        state_d = S_CALC;
      end

      S_CALC: begin
        freq_d    = freq_round;
        off_d     = off_clamp;
        ptr_d     = '0;
        cmp_vld_d = 1'b0;
        state_d   = S_SEARCH;
      end

      // One read issued and one compare done per cycle
      S_SEARCH: begin
        mem_raddr = ptr_q[IDX_W-1:0];
        if (cmp_vld_q && (mem_rdata.freq == freq_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          changed_d = (mem_rdata.offset != off_q);
          cmp_vld_d = 1'b0;
          state_d   = S_APPLY;
        end else if (ptr_q < count_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + 1'b1;
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else begin
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        ok_d = 1'b1;
        if (hit_q) begin
          cur_d     = hit_idx_q;
          mem_waddr = hit_idx_q;
          mem_we    = changed_q;
        end else begin
          changed_d = 1'b1;
          mem_we    = 1'b1;
          if (count_q < MAX_CNT) begin
            mem_waddr = count_q[IDX_W-1:0];
            cur_d     = count_q[IDX_W-1:0];
            count_d   = count_q + 1'b1;
          end
        end
        state_d = S_RDSEL;
      end

      // Wrap the current index inside the filled part of the table
      S_STEP: begin
        if (count_q != '0) begin
          ok_d      = 1'b1;
          changed_d = 1'b1;
          if (op_q == OP_NEXT) begin
            if (CNT_W'(cur_q) + 1'b1 == count_q) begin
              cur_d = '0;
            end else begin
              cur_d = cur_q + 1'b1;
            end
          end else if (cur_q == '0) begin
            cur_d = IDX_W'(count_q - 1'b1);
          end else begin
            cur_d = cur_q - 1'b1;
          end
        end
        state_d = S_RDSEL;
      end

      S_RDSEL: begin
        mem_raddr = cur_q;
        state_d   = S_RESP;
      end

      S_RESP: begin
        mem_raddr = cur_q;
        if (!out_valid_q || out_ready_i) begin
          res_d.ok          = ok_q;
          res_d.hit         = hit_q;
          res_d.sel_index   = 4'(cur_q);
          res_d.entry_count = 5'(count_q);
          res_d.changed     = changed_q;
          if (count_q != '0) begin
            res_d.sel_freq   = mem_rdata.freq;
            res_d.sel_offset = mem_rdata.offset;
          end else begin
            res_d.sel_freq   = '0;
            res_d.sel_offset = '0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= cmp_vld_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    freq_raw_q <= freq_raw_d;
    off_raw_q  <= off_raw_d;
    quot_q     <= quot_d;
    freq_q     <= freq_d;
    off_q      <= off_d;
    ptr_q      <= ptr_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_q      <= hit_d;
    ok_q       <= ok_d;
    changed_q  <= changed_d;
    res_q      <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count above table depth");

  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CNT_W'(cur_q) < count_q))
    else $error("current index outside filled entries");

  a_count_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> $stable(count_q))
    else $error("entry count changed outside apply step");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside response step");

endmodule

// ----- design/rpt_store.sv -----
// Preset storage: one write port, one registered read port.
// Depends on rpt_pkg for the entry type.
`timescale 1ns / 1ps

module rpt_store
  import rpt_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ENTRIES_DEF,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/radio_preset_table_tb.sv -----
// Self-checking testbench for radio_preset_table: directed and random tuner preset
// operations under changing offset limits and random handshake pressure.
// Depends on rpt_pkg and the radio_preset_table RTL.
`timescale 1ns / 1ps

module radio_preset_table_tb;
  import rpt_pkg::*;

  localparam int          CLK_PERIOD     = 4;
  localparam int          TBL_DEPTH      = MAX_ENTRIES_DEF;
  localparam int          RND_STEP       = 10;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          MAX_REPORTS    = 200;
  localparam longint      TIMEOUT_NS     = 64'd4_000_000;
  // Frequency pool: more distinct channels than table slots, so full-table misses occur
  localparam int          FREQ_POOL_SIZE = 24;
  localparam int          FREQ_POOL_STEP = 130;
  // Opcode left unused by the block
  localparam logic [1:0]  OP_NOP         = 2'd3;
  // Register indexes the block ignores
  localparam logic [1:0]  CFG_SPARE_2    = 2'd2;
  localparam logic [1:0]  CFG_SPARE_3    = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  rpt_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rpt_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_OFFSET_MIN;
  logic [15:0] cfg_data_i  = '0;

  // Mirror of the preset table
  logic [13:0]        freq_tbl [TBL_DEPTH];
  logic signed [15:0] ofs_tbl  [TBL_DEPTH];
  int                 tbl_count = 0;
  int                 cur_idx   = 0;
  int                 lim_min   = OFFSET_MIN_RST;
  int                 lim_max   = OFFSET_MAX_RST;

  rpt_out_t predicted_status_q [$];
  int       mismatch_cnt = 0;
  int       idle_pct     = 0;
  int       stall_pct    = 0;

  radio_preset_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one operation to the mirrored table and return the expected status
  function automatic rpt_out_t predict_preset(rpt_in_t op);
    rpt_out_t res;
    int       f;
    int       o;
    int       hit_at;
    res    = '0;
    hit_at = -1;
    case (op.opcode)
      OP_ADD: begin
        f = op.freq_in;
        if (f < BAND_LOW) f = BAND_LOW;
        else if (f > BAND_HIGH) f = BAND_HIGH;
        f = ((f + ROUND_HALF) / RND_STEP) * RND_STEP;
        if (f > BAND_HIGH) f = BAND_HIGH;
        o = $signed(op.offset_in);
        if (o < lim_min) o = lim_min;
        else if (o > lim_max) o = lim_max;
        res.ok = 1'b1;
        for (int i = 0; i < tbl_count; i++) begin
          if (hit_at < 0 && freq_tbl[i] == f[13:0]) hit_at = i;
        end
        if (hit_at >= 0) begin
          res.hit = 1'b1;
          cur_idx = hit_at;
          if (ofs_tbl[hit_at] != o[15:0]) begin
            ofs_tbl[hit_at] = o[15:0];
            res.changed     = 1'b1;
          end
        end else begin
          // append, or overwrite the current slot when full
          if (tbl_count < TBL_DEPTH) begin
            cur_idx = tbl_count;
            tbl_count++;
          end else if (cur_idx >= TBL_DEPTH) begin
            cur_idx = 0;
          end
          freq_tbl[cur_idx] = f[13:0];
          ofs_tbl[cur_idx]  = o[15:0];
          res.changed       = 1'b1;
        end
      end
      OP_NEXT, OP_PREV: begin
        if (tbl_count != 0) begin
          res.ok      = 1'b1;
          res.changed = 1'b1;
          if (op.opcode == OP_NEXT) cur_idx = (cur_idx + 1) % tbl_count;
          else if (cur_idx == 0) cur_idx = tbl_count - 1;
          else cur_idx--;
        end
      end
      default: ;
    endcase
    res.sel_index   = cur_idx[3:0];
    res.entry_count = tbl_count[4:0];
    if (tbl_count != 0) begin
      res.sel_freq   = freq_tbl[cur_idx];
      res.sel_offset = ofs_tbl[cur_idx];
    end
    return res;
  endfunction

  function automatic rpt_in_t preset_op(logic [1:0] opc, logic [15:0] f, logic [15:0] o);
    rpt_in_t t;
    t.opcode    = opc;
    t.freq_in   = f;
    t.offset_in = o;
    return t;
  endfunction

  function automatic logic [15:0] random_freq();
    int pick;
    int f;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // popular channels with jitter that rounds back onto the channel
      f = FREQ_POOL_STEP * int'($urandom_range(FREQ_POOL_SIZE - 1));
      f = f + BAND_LOW + int'($urandom_range(8)) - 4;
    end else if (pick < 65) begin
      f = $urandom_range(16'hFFFF);
    end else if (pick < 80) begin
      f = $urandom_range(1) ? BAND_HIGH : BAND_LOW;
      f = f + int'($urandom_range(30)) - 15;
    end else begin
      f = $urandom_range(BAND_HIGH, BAND_LOW);
    end
    return f[15:0];
  endfunction

  function automatic logic [15:0] random_offset();
    int pick;
    int o;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // coarse values repeat often, giving hits with an unchanged offset
      o = (int'($urandom_range(16)) - 8) * 100;
    end else if (pick < 75) begin
      o = $urandom_range(16'hFFFF);
    end else begin
      o = ($urandom_range(1) ? lim_min : lim_max) + int'($urandom_range(4)) - 2;
    end
    return o[15:0];
  endfunction

  function automatic rpt_in_t random_preset_op();
    int         pick;
    logic [1:0] opc;
    pick = $urandom_range(99);
    if (pick < 55) opc = OP_ADD;
    else if (pick < 75) opc = OP_NEXT;
    else if (pick < 95) opc = OP_PREV;
    else opc = OP_NOP;
    return preset_op(opc, random_freq(), random_offset());
  endfunction

  // Send one operation; valid stays high on return so the next one can follow
  task automatic send_item(input rpt_in_t op);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_status_q.push_back(predict_preset(op));
  endtask

  // Drive one register write; caller lowers valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OFFSET_MIN: lim_min = $signed(val);
      CFG_OFFSET_MAX: lim_max = $signed(val);
      default: ;
    endcase
  endtask

  task automatic set_offset_limits(input int lo, input int hi);
    write_reg(CFG_OFFSET_MIN, lo[15:0]);
    write_reg(CFG_OFFSET_MAX, hi[15:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // Let every outstanding result arrive, then give the block time to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      if (mismatch_cnt < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
      mismatch_cnt++;
    end
  endtask

  // Result checker; ready is re-randomized every cycle
  always @(posedge clk_i) begin
    rpt_out_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (predicted_status_q.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none actual %h", $time, out_data_o);
        mismatch_cnt++;
      end else begin
        exp_res = predicted_status_q.pop_front();
        report_field("ok", exp_res.ok, out_data_o.ok);
        report_field("hit", exp_res.hit, out_data_o.hit);
        report_field("sel_index", exp_res.sel_index, out_data_o.sel_index);
        report_field("sel_freq", exp_res.sel_freq, out_data_o.sel_freq);
        report_field("sel_offset", $signed(exp_res.sel_offset),
                     $signed(out_data_o.sel_offset));
        report_field("entry_count", exp_res.entry_count, out_data_o.entry_count);
        report_field("changed", exp_res.changed, out_data_o.changed);
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Steps and the unused opcode on an empty table must fail without side effects
  task automatic test_empty_table();
    send_item(preset_op(OP_NEXT, 16'hFFFF, 16'hFFFF));
    send_item(preset_op(OP_PREV, 16'h0000, 16'h8000));
    send_item(preset_op(OP_NOP, 16'h2A30, 16'h7FFF));
    drain();
  endtask

  // Band clamping, rounding, offset clamping, hits with and without offset change
  task automatic test_add_select();
    send_item(preset_op(OP_ADD, 16'h0000, 16'h8000));
    send_item(preset_op(OP_ADD, 16'hFFFF, 16'h7FFF));
    send_item(preset_op(OP_ADD, 16'd7604, 16'd0));
    send_item(preset_op(OP_ADD, 16'd7604, 16'd0));
    send_item(preset_op(OP_ADD, 16'd7605, 16'd599));
    send_item(preset_op(OP_ADD, 16'd10795, 16'd600));
    send_item(preset_op(OP_ADD, 16'd9001, 16'd601));
    send_item(preset_op(OP_ADD, 16'd8999, -16'sd601));
    drain();
  endtask

  // Index wrap in both directions and the unused opcode on a filled table
  task automatic test_step_wrap();
    send_item(preset_op(OP_NEXT, 16'd0, 16'd0));
    send_item(preset_op(OP_PREV, 16'd0, 16'd0));
    send_item(preset_op(OP_PREV, 16'd0, 16'd0));
    send_item(preset_op(OP_NEXT, 16'd0, 16'd0));
    send_item(preset_op(OP_NOP, 16'd9000, 16'd100));
    drain();
  endtask

  // Fill all slots, then misses overwrite the current entry
  task automatic test_full_table();
    for (int i = 0; i < 12; i++)
      send_item(preset_op(OP_ADD, 16'd8020 + 16'(i * 100), 16'(i * 50)));
    send_item(preset_op(OP_ADD, 16'd10500, -16'sd50));
    send_item(preset_op(OP_PREV, 16'd0, 16'd0));
    send_item(preset_op(OP_ADD, 16'd7777, 16'd300));
    send_item(preset_op(OP_NEXT, 16'd0, 16'd0));
    drain();
  endtask

  // Writes to unmapped indexes must leave the limits alone
  task automatic test_spare_cfg_index();
    write_reg(CFG_SPARE_2, 16'h5555);
    write_reg(CFG_SPARE_3, 16'hAAAA);
    cfg_valid_i <= 1'b0;
    send_item(preset_op(OP_ADD, 16'd9500, 16'h7FFF));
    send_item(preset_op(OP_ADD, 16'd9500, 16'h8000));
    drain();
  endtask

  task automatic test_random_phase(input int lo, input int hi, input int idle,
                                   input int stall, input int n_ops);
    set_offset_limits(lo, hi);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_ops; i++) send_item(random_preset_op());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_select();
    test_step_wrap();
    test_full_table();
    test_spare_cfg_index();
    test_random_phase(-32768, 32767, 0, 0, 250);
    test_random_phase(200, -200, 75, 0, 250);
    test_random_phase(32767, 32767, 0, 75, 250);
    test_random_phase(-32768, -32768, 13, 13, 250);
    test_random_phase(-600, 600, 0, 0, 250);
    test_random_phase(-1500, 40, 13, 13, 250);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
